### rtl/pwbt_pkg.sv
package pwbt_pkg;

    // Frame buffer geometry.
    localparam int BUF_DEPTH = 16;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int LEN_W     = $clog2(BUF_DEPTH + 1);

    // Field widths fixed by the interface.
    localparam int OPC_W  = 2;
    localparam int IDX_W  = 4;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 8;
    localparam int TIME_W = 16;
    localparam int CUR_W  = 4;
    localparam int REG_W  = 2;

    typedef logic [OPC_W-1:0]  t_opcode;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [CUR_W-1:0]  t_cursor;
    typedef logic [REG_W-1:0]  t_reg_idx;

    // Input opcodes.
    localparam t_opcode OP_WRITE = 2'd0;
    localparam t_opcode OP_START = 2'd1;
    localparam t_opcode OP_TICK  = 2'd2;

    // Configuration register indexes.
    localparam t_reg_idx REG_HIGH_TIME = 2'd0;
    localparam t_reg_idx REG_SYNC_GAP  = 2'd1;
    localparam t_reg_idx REG_SHORT_GAP = 2'd2;
    localparam t_reg_idx REG_LONG_GAP  = 2'd3;

    // Reset values of the timing registers.
    localparam t_time RST_HIGH_TIME = 16'd540;
    localparam t_time RST_SYNC_GAP  = 16'd4000;
    localparam t_time RST_SHORT_GAP = 16'd900;
    localparam t_time RST_LONG_GAP  = 16'd1900;

    // Bit cursor codes: values below FIRST_BIT+1 are bit indexes.
    localparam t_cursor CUR_SYNC  = 4'hE;
    localparam t_cursor CUR_NEXT  = 4'hF;
    localparam t_cursor FIRST_BIT = 4'h7;

endpackage

### rtl/pwbt_in_if.sv
interface pwbt_in_if;
    logic                             valid;
    logic                             ready;
    pwbt_pkg::t_opcode                opcode;
    logic [pwbt_pkg::IDX_W-1:0]       byte_index;
    logic [pwbt_pkg::BYTE_W-1:0]      data_byte;
    logic [pwbt_pkg::CNT_W-1:0]       frame_length;
    logic [pwbt_pkg::CNT_W-1:0]       repeat_count;

    modport source (
        output valid, opcode, byte_index, data_byte, frame_length, repeat_count,
        input  ready
    );
    modport sink (
        input  valid, opcode, byte_index, data_byte, frame_length, repeat_count,
        output ready
    );
endinterface

### rtl/pwbt_out_if.sv
interface pwbt_out_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic busy_res;
    logic accepted;

    modport source (
        output valid, pin_level, busy_res, accepted,
        input  ready
    );
    modport sink (
        input  valid, pin_level, busy_res, accepted,
        output ready
    );
endinterface

### rtl/pulse_width_burst_transmitter_unit.sv
// Timing: the result beat for an input beat is registered and presented in the cycle after it is accepted.
// Throughput: one input beat per cycle; the only limit is the single output register,
// which frees itself in the same cycle that its beat is taken.
// Reset (synchronous, active low): burst control and the output valid flag are cleared and
// the timing registers return to their defaults; the frame buffer holds no reset value.
module pulse_width_burst_transmitter_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  pwbt_pkg::t_reg_idx          i_cfg_idx,
    input  pwbt_pkg::t_time             i_cfg_data,
    pwbt_in_if.sink                     i_in,
    pwbt_out_if.source                  o_out
);

    // Timing registers, written through the configuration port.
    pwbt_pkg::t_time r_high_time;
    pwbt_pkg::t_time r_sync_gap;
    pwbt_pkg::t_time r_short_gap;
    pwbt_pkg::t_time r_long_gap;

    // Frame buffer. It is small and read at a single address, so it lives in flops.
    logic [pwbt_pkg::BYTE_W-1:0] r_frame_buffer [pwbt_pkg::BUF_DEPTH];

    // Burst sequencing state.
    logic [pwbt_pkg::LEN_W-1:0]  r_active_length, n_active_length;
    logic [pwbt_pkg::CNT_W-1:0]  r_bursts_left,   n_bursts_left;
    logic [pwbt_pkg::LEN_W-1:0]  r_byte_position, n_byte_position;
    pwbt_pkg::t_cursor           r_bit_cursor,    n_bit_cursor;
    logic                        r_pin_state,     n_pin_state;
    pwbt_pkg::t_time             r_interval_left, n_interval_left;

    // Output register.
    logic r_out_valid;
    logic r_out_pin;
    logic r_out_busy;
    logic r_out_acc;
    logic n_acc;

    logic in_beat;
    logic buf_we;

    // The output register parts the two sides: a new beat is taken whenever the
    // register is empty or its current beat leaves in this cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_beat    = i_in.valid && i_in.ready;

    assign o_out.valid     = r_out_valid;
    assign o_out.pin_level = r_out_pin;
    assign o_out.busy_res  = r_out_busy;
    assign o_out.accepted  = r_out_acc;

    // Byte writes are taken only while no burst runs and the index fits the buffer.
    assign buf_we = in_beat && (i_in.opcode == pwbt_pkg::OP_WRITE) && (r_bursts_left == '0)
                    && (32'(i_in.byte_index) < pwbt_pkg::BUF_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_time  <= pwbt_pkg::RST_HIGH_TIME;
            r_sync_gap   <= pwbt_pkg::RST_SYNC_GAP;
            r_short_gap  <= pwbt_pkg::RST_SHORT_GAP;
            r_long_gap   <= pwbt_pkg::RST_LONG_GAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pwbt_pkg::REG_HIGH_TIME: r_high_time <= i_cfg_data;
                pwbt_pkg::REG_SYNC_GAP:  r_sync_gap  <= i_cfg_data;
                pwbt_pkg::REG_SHORT_GAP: r_short_gap <= i_cfg_data;
                pwbt_pkg::REG_LONG_GAP:  r_long_gap  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_frame_buffer[i_in.byte_index[pwbt_pkg::BUF_AW-1:0]] <= i_in.data_byte;
        end
    end

    // One pass of the sequencer. A tick counts the current interval down; when it
    // runs out, the next level and its duration are chosen. Running out means the
    // count reaches zero after the decrement, so a duration of zero lasts one tick.
    always_comb begin
        logic                        busy;
        logic [pwbt_pkg::CNT_W-1:0]  len_clamped;
        pwbt_pkg::t_time             il_dec;
        logic [pwbt_pkg::BYTE_W-1:0] byte_val;
        logic [2:0]                  bit_sel;

        busy            = (r_bursts_left != '0);
        len_clamped     = '0;
        il_dec          = '0;
        byte_val        = '0;
        bit_sel         = '0;
        n_active_length = r_active_length;
        n_bursts_left   = r_bursts_left;
        n_byte_position = r_byte_position;
        n_bit_cursor    = r_bit_cursor;
        n_pin_state     = r_pin_state;
        n_interval_left = r_interval_left;
        n_acc           = 1'b0;

        case (i_in.opcode)
            pwbt_pkg::OP_WRITE: begin
                n_acc = buf_we;
            end
            pwbt_pkg::OP_START: begin
                if (!busy) begin
                    n_acc = 1'b1;
                    len_clamped = (32'(i_in.frame_length) > pwbt_pkg::BUF_DEPTH)
                                  ? pwbt_pkg::CNT_W'(pwbt_pkg::BUF_DEPTH)
                                  : i_in.frame_length;
                    n_byte_position = '0;
                    n_bit_cursor    = pwbt_pkg::CUR_SYNC;
                    n_pin_state     = 1'b0;
                    n_interval_left = '0;
                    // A zero length or repeat count leaves the block idle.
                    if (len_clamped != '0 && i_in.repeat_count != '0) begin
                        n_active_length = len_clamped[pwbt_pkg::LEN_W-1:0];
                        n_bursts_left   = i_in.repeat_count;
                    end else begin
                        n_active_length = '0;
                        n_bursts_left   = '0;
                    end
                end
            end
            pwbt_pkg::OP_TICK: begin
                if (busy) begin
                    il_dec = (r_interval_left != '0) ? r_interval_left - 1'b1 : r_interval_left;
                    n_interval_left = il_dec;
                    if (il_dec == '0) begin
                        if (r_active_length == '0) begin
                            n_bursts_left = '0;
                            n_pin_state   = 1'b0;
                        end else begin
                            // Step to the next byte after its last bit went out.
                            if (n_bit_cursor == pwbt_pkg::CUR_NEXT) begin
                                n_bit_cursor    = pwbt_pkg::FIRST_BIT;
                                n_byte_position = n_byte_position + 1'b1;
                            end
                            // End of frame: rewind and count one repetition off.
                            if (n_byte_position >= r_active_length) begin
                                n_byte_position = '0;
                                n_bit_cursor    = pwbt_pkg::CUR_SYNC;
                                n_bursts_left   = n_bursts_left - 1'b1;
                            end
                            if (n_bursts_left == '0) begin
                                n_pin_state = 1'b0;
                            end else if (r_pin_state) begin
                                // High pulse done: follow with the gap that codes it.
                                n_pin_state = 1'b0;
                                if (n_bit_cursor == pwbt_pkg::CUR_SYNC) begin
                                    n_interval_left = r_sync_gap;
                                    n_bit_cursor    = pwbt_pkg::FIRST_BIT;
                                end else begin
                                    if (32'(n_byte_position) < pwbt_pkg::BUF_DEPTH) begin
                                        byte_val = r_frame_buffer[
                                            n_byte_position[pwbt_pkg::BUF_AW-1:0]];
                                    end
                                    bit_sel = n_bit_cursor[2:0];
                                    n_interval_left = byte_val[bit_sel] ? r_long_gap
                                                                        : r_short_gap;
                                    n_bit_cursor = n_bit_cursor - 1'b1;
                                end
                            end else begin
                                n_pin_state     = 1'b1;
                                n_interval_left = r_high_time;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_length <= '0;
            r_bursts_left   <= '0;
            r_byte_position <= '0;
            r_bit_cursor    <= pwbt_pkg::CUR_SYNC;
            r_pin_state     <= 1'b0;
            r_interval_left <= '0;
        end else if (in_beat) begin
            r_active_length <= n_active_length;
            r_bursts_left   <= n_bursts_left;
            r_byte_position <= n_byte_position;
            r_bit_cursor    <= n_bit_cursor;
            r_pin_state     <= n_pin_state;
            r_interval_left <= n_interval_left;
        end
    end

    // The result beat reports the state left behind by its input beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out_pin  <= n_pin_state;
            r_out_busy <= (n_bursts_left != '0);
            r_out_acc  <= n_acc;
        end
    end

    // The pin rests low whenever no burst is running.
    a_idle_pin_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bursts_left == '0) |-> !r_pin_state)
        else $error("pin high while idle");

    // A write or start that arrives during a burst must be reported as ignored.
    a_busy_not_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && r_bursts_left != '0
         && (i_in.opcode == pwbt_pkg::OP_WRITE || i_in.opcode == pwbt_pkg::OP_START))
        |=> !r_out_acc)
        else $error("beat taken while busy");

    // During a burst the byte pointer stays inside the active frame.
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bursts_left != '0) |-> (r_byte_position < r_active_length))
        else $error("byte position beyond frame");

    // The reported busy flag follows the burst counter it was taken from.
    a_busy_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_out_busy == (r_bursts_left != '0)))
        else $error("busy flag mismatch");

endmodule
